/* src/stq_pkg.sv */
// stq_pkg: shared types and constants for the sorted timer queue
// no dependencies; imported by stq_cell and sorted_timer_queue_unit

package stq_pkg;

    // queue size and derived widths
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DEADLINE_W  = 32;
    localparam int TASK_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;

    // action selector on the input side
    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_POP    = 1'b1
    } stq_action_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } stq_status_t;

    // one stored timer
    typedef struct packed {
        logic [DEADLINE_W-1:0] deadline;
        logic [TASK_W-1:0]     task_id;
    } stq_entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } stq_ctrl_t;

endpackage

/* src/stq_cell.sv */
// stq_cell: one slot of the sorted timer queue chain
// depends on stq_pkg for the entry and command types

module stq_cell
    import stq_pkg::*;
(
    input  logic       aclk,
    input  stq_ctrl_t  ctrl,
    input  stq_entry_t new_entry,
    input  logic       occupied,
    input  logic       place_left,
    input  stq_entry_t left_entry,
    input  stq_entry_t right_entry,
    output logic       place,
    output stq_entry_t entry
);

    stq_entry_t entry_reg;
    stq_entry_t entry_next;

    // new item belongs at or before this slot: slot is free or holds a later deadline
    assign place = !occupied || (entry_reg.deadline > new_entry.deadline);
    assign entry = entry_reg;

    // insert shifts toward the tail, pop shifts toward the head
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins && place) begin
            entry_next = place_left ? left_entry : new_entry;
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

/* src/sorted_timer_queue_unit.sv */
// Sorted timer queue: keeps up to QUEUE_DEPTH timers ordered by deadline in a
// chain of slot cells. An insert item lands behind every entry with an equal or
// earlier deadline; a pop item removes the head and returns its task id. Every
// item gives exactly one result, registered in the cycle after the item is taken.
// One item is accepted per cycle: all cells compare against the new deadline in
// parallel and shift by one place in the same cycle, so the compare-and-shift
// step of the cell chain sets the rate. The input stalls only while a result
// waits on the output and is not taken in that cycle.
// depends on stq_pkg and stq_cell

module sorted_timer_queue_unit
    import stq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // deadline_ms[31:0], task_id[39:32]
    input  logic [0:0]  s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // woken_task[7:0], occupancy[12:8], zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    logic                 accept;
    stq_action_t          action;
    stq_entry_t           new_entry;
    logic                 full;
    logic                 empty;
    stq_ctrl_t            ctrl;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    stq_status_t          status_reg;
    stq_status_t          status_next;
    logic [TASK_W-1:0]    woken_reg;
    logic [TASK_W-1:0]    woken_next;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic [QUEUE_DEPTH-1:0] place;
    stq_entry_t           entries [QUEUE_DEPTH];

    // input unpacking and handshake
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = stq_action_t'(s_axis_tuser[0]);
    assign new_entry     = {s_axis_tdata[31:0], s_axis_tdata[39:32]};

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // command to the cell chain
    always_comb begin
        ctrl.ins = accept && (action == ACT_INSERT) && !full;
        ctrl.pop = accept && (action == ACT_POP) && !empty;
    end

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic       occ_c;
            logic       pl_left;
            stq_entry_t left_e;
            stq_entry_t right_e;

            assign occ_c = (CNT_W'(gi) < count_reg);
            if (gi == 0) begin : g_head
                assign pl_left = 1'b0;
                assign left_e  = new_entry;
            end else begin : g_mid
                assign pl_left = place[gi-1];
                assign left_e  = entries[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign right_e = entries[gi];
            end else begin : g_inner
                assign right_e = entries[gi+1];
            end

            stq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .occupied    (occ_c),
                .place_left  (pl_left),
                .left_entry  (left_e),
                .right_entry (right_e),
                .place       (place[gi]),
                .entry       (entries[gi])
            );
        end
    endgenerate

    // count and result formation
    always_comb begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        woken_next     = woken_reg;
        occ_next       = occ_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            out_valid_next = 1'b1;
            woken_next     = '0;
            if (ctrl.ins) begin
                count_next  = count_reg + 1'b1;
                status_next = ST_INSERTED;
            end else if (ctrl.pop) begin
                count_next  = count_reg - 1'b1;
                status_next = ST_POPPED;
                woken_next  = entries[0].task_id;
            end else if (action == ACT_POP) begin
                status_next = ST_EMPTY;
            end else begin
                status_next = ST_FULL;
            end
            occ_next = OCC_W'(count_next);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        woken_reg  <= woken_next;
        occ_reg    <= occ_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {3'b000, occ_reg, woken_reg};

endmodule
